/* src/qrca_pkg.sv */
// ----------------------------------------------------------------------------
// qrca_pkg
// Shared constants, register codes and the classified pixel word for the
// quad region color average block.
// ----------------------------------------------------------------------------
package qrca_pkg;

	// Frame and coordinate geometry.
	localparam int MaxFrameSide = 4096;
	localparam int CoordW = 12;
	localparam int FracBits = 12;
	localparam int ChanW = 8;
	localparam int NumChan = 3;

	// Configuration port.
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 40;
	localparam int FieldW = 20;
	localparam int ScaleW = 20;
	localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(65536);

	// Span arithmetic: scaled corners, differences, magnitudes, products.
	localparam int ScaledW = 28;
	localparam int DiffW = ScaledW + 1;
	localparam int MagW = ScaledW;
	localparam int ProdW = 2 * MagW;
	localparam int PosW = ProdW + 2;
	localparam int NumEdges = 4;
	localparam int EdgeW = 2;

	// Accumulators.
	localparam int SumW = 32;
	localparam int CountW = 25;

	// Queue between front and back.
	localparam int FifoDepth = 4;
	localparam int FifoPtrW = 2;
	localparam int FifoCntW = 3;

	// Register indexes on the configuration port.
	typedef enum logic [CfgIdxW-1:0] {
		REG_CORNER_ONE   = 3'd0,
		REG_CORNER_TWO   = 3'd1,
		REG_CORNER_THREE = 3'd2,
		REG_CORNER_FOUR  = 3'd3,
		REG_SCALE_X      = 3'd4,
		REG_SCALE_Y      = 3'd5
	} reg_idx_t;

	// One classified pixel as it travels from front to back.
	typedef struct packed {
		logic                         covered;
		logic [NumChan-1:0][ChanW-1:0] weight;
		logic                         last;
	} cls_t;

	// floor(c * a / 255) without a divider; exact for every byte pair.
	function automatic logic [ChanW-1:0] alpha_weight(input logic [ChanW-1:0] c,
		input logic [ChanW-1:0] a);
		logic [2*ChanW-1:0] p;
		logic [2*ChanW:0] t;
		p = c * a;
		t = {1'b0, p} + (2*ChanW+1)'(1) + (2*ChanW+1)'(p[2*ChanW-1:ChanW]);
		return t[2*ChanW-1:ChanW];
	endfunction

endpackage

/* src/qrca_pix_if.sv */
// ----------------------------------------------------------------------------
// qrca_pix_if
// Pixel stream channel: position, color bytes and the end-of-frame mark.
// ----------------------------------------------------------------------------
interface qrca_pix_if;
	import qrca_pkg::*;

	logic              valid;
	logic              ready;
	logic [CoordW-1:0] pix_x;
	logic [CoordW-1:0] pix_y;
	logic [ChanW-1:0]  red;
	logic [ChanW-1:0]  green;
	logic [ChanW-1:0]  blue;
	logic [ChanW-1:0]  alpha;
	logic              frame_end;

	modport source (output valid, pix_x, pix_y, red, green, blue, alpha, frame_end,
		input ready);
	modport sink (input valid, pix_x, pix_y, red, green, blue, alpha, frame_end,
		output ready);
endinterface

/* src/qrca_res_if.sv */
// ----------------------------------------------------------------------------
// qrca_res_if
// Result channel: per-frame average colors and the covered pixel count.
// ----------------------------------------------------------------------------
interface qrca_res_if;
	import qrca_pkg::*;

	logic              valid;
	logic              ready;
	logic [ChanW-1:0]  avg_red;
	logic [ChanW-1:0]  avg_green;
	logic [ChanW-1:0]  avg_blue;
	logic [CountW-1:0] covered_count;

	modport source (output valid, avg_red, avg_green, avg_blue, covered_count,
		input ready);
	modport sink (input valid, avg_red, avg_green, avg_blue, covered_count,
		output ready);
endinterface

/* src/qrca_cfg_if.sv */
// ----------------------------------------------------------------------------
// qrca_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qrca_cfg_if;
	import qrca_pkg::*;

	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/qrca_front.sv */
// ----------------------------------------------------------------------------
// qrca_front
// Holds the configuration, works out the covered span of each new row with a
// shared shift-add multiplier and restoring divider, and classifies pixels.
// ----------------------------------------------------------------------------
module qrca_front (
	input  logic            clk,
	input  logic            arst_n,
	qrca_pix_if.sink        pix,
	qrca_cfg_if.sink        cfg,
	output logic            push_valid,
	output qrca_pkg::cls_t  push_data,
	input  logic            push_room
);
	import qrca_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE, F_EDGE, F_MUL, F_DIV, F_ACC, F_DONE, F_PUSH
	} fstate_t;

	localparam int StepW = 6;
	localparam int IntW = PosW - FracBits;

	// Configuration registers.
	logic [CfgDataW-1:0] corner_q [NumEdges];
	logic [ScaleW-1:0]   scale_x_q;
	logic [ScaleW-1:0]   scale_y_q;

	// Scaled corners, refreshed every cycle from the registers.
	logic signed [ScaledW-1:0] xs_q [NumEdges];
	logic signed [ScaledW-1:0] ys_q [NumEdges];

	// Cached span of the latest row.
	logic              span_valid_q;
	logic [CoordW-1:0] span_row_q;
	logic              span_present_q;
	logic [CoordW-1:0] span_left_q;
	logic [CoordW-1:0] span_right_q;

	// Span engine.
	fstate_t             state_q;
	logic [EdgeW-1:0]    edge_q;
	logic                any_q;
	logic [CoordW-1:0]   lo_q;
	logic [CoordW-1:0]   hi_q;
	logic [ScaledW-1:0]  x0_q;
	logic [MagW-1:0]     ma_q;
	logic [MagW-1:0]     mb_q;
	logic [MagW-1:0]     dmag_q;
	logic                neg_q;
	logic [ProdW-1:0]    p_q;
	logic [MagW-1:0]     rem_q;
	logic [StepW-1:0]    step_q;

	// Held pixel while its row span is worked out.
	logic [CoordW-1:0]             hold_x_q;
	logic [CoordW-1:0]             hold_y_q;
	logic [NumChan-1:0][ChanW-1:0] hold_w_q;
	logic                          hold_last_q;

	logic accept;
	logic hit;

	function automatic logic signed [ScaledW-1:0] scale_coord(input logic [FieldW-1:0] c,
		input logic [ScaleW-1:0] s);
		logic signed [FieldW+ScaleW:0] p;
		p = $signed(c) * $signed({1'b0, s});
		return p[FieldW+ScaleW-1:FieldW+ScaleW-ScaledW];
	endfunction

	function automatic logic [MagW-1:0] magnitude(input logic signed [DiffW-1:0] v);
		logic signed [DiffW-1:0] n;
		n = -v;
		return v[DiffW-1] ? n[MagW-1:0] : v[MagW-1:0];
	endfunction

	// Configuration writes; any write drops the cached span.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumEdges; i++) begin
				corner_q[i] <= '0;
			end
			scale_x_q <= ScaleReset;
			scale_y_q <= ScaleReset;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_CORNER_ONE:   corner_q[0] <= cfg.data;
				REG_CORNER_TWO:   corner_q[1] <= cfg.data;
				REG_CORNER_THREE: corner_q[2] <= cfg.data;
				REG_CORNER_FOUR:  corner_q[3] <= cfg.data;
				REG_SCALE_X:      scale_x_q <= cfg.data[ScaleW-1:0];
				REG_SCALE_Y:      scale_y_q <= cfg.data[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	// Corner scaling, one multiplier per coordinate.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NumEdges; i++) begin
			xs_q[i] <= scale_coord(corner_q[i][CfgDataW-1:FieldW], scale_x_q);
			ys_q[i] <= scale_coord(corner_q[i][FieldW-1:0], scale_y_q);
		end
	end

	// Pixel intake and classification.
	assign hit = span_valid_q && (span_row_q == pix.pix_y);
	assign pix.ready = (state_q == F_IDLE) && push_room;
	assign accept = pix.valid && pix.ready;

	logic [NumChan-1:0][ChanW-1:0] in_w;
	always_comb begin
		in_w[0] = alpha_weight(pix.red, pix.alpha);
		in_w[1] = alpha_weight(pix.green, pix.alpha);
		in_w[2] = alpha_weight(pix.blue, pix.alpha);
	end

	always_comb begin
		logic [CoordW-1:0] sx;
		sx = (state_q == F_PUSH) ? hold_x_q : pix.pix_x;
		push_valid = (accept && hit) || ((state_q == F_PUSH) && push_room);
		push_data.covered = span_present_q && (sx >= span_left_q) && (sx <= span_right_q);
		push_data.weight = (state_q == F_PUSH) ? hold_w_q : in_w;
		push_data.last = (state_q == F_PUSH) ? hold_last_q : pix.frame_end;
	end

	// Edge set-up: crossing test and operand magnitudes.
	logic signed [DiffW-1:0] yc, ey0, ey1, ex0, ex1, dy, dx, den;
	logic                    skip;
	always_comb begin
		yc = DiffW'($signed({1'b0, hold_y_q, {FracBits{1'b0}}}));
		ey0 = DiffW'(ys_q[edge_q]);
		ey1 = DiffW'(ys_q[edge_q + EdgeW'(1)]);
		ex0 = DiffW'(xs_q[edge_q]);
		ex1 = DiffW'(xs_q[edge_q + EdgeW'(1)]);
		dy = yc - ey0;
		dx = ex1 - ex0;
		den = ey1 - ey0;
		skip = (ey0 == ey1) ||
			((yc < ey0) && (yc < ey1)) || ((yc > ey0) && (yc > ey1));
	end

	// Divider step and crossing position.
	logic [MagW:0]     rtrial;
	logic              qbit;
	logic [PosW-1:0]   qsel;
	logic [PosW-1:0]   pos;
	logic [CoordW-1:0] end_pos;
	always_comb begin
		rtrial = {rem_q, p_q[ProdW-1]};
		qbit = rtrial >= {1'b0, dmag_q};
		qsel = neg_q ? ~{2'b00, p_q} : {2'b00, p_q};
		pos = {{(PosW-ScaledW){x0_q[ScaledW-1]}}, x0_q} + qsel +
			PosW'(neg_q && (rem_q == '0));
		if (pos[PosW-1]) begin
			end_pos = '0;
		end else if (pos[PosW-1:FracBits] > IntW'(MaxFrameSide - 1)) begin
			end_pos = CoordW'(MaxFrameSide - 1);
		end else begin
			end_pos = pos[FracBits+CoordW-1:FracBits];
		end
	end

	// Span engine sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			span_valid_q <= 1'b0;
			span_row_q <= '0;
			span_present_q <= 1'b0;
			span_left_q <= '0;
			span_right_q <= '0;
			edge_q <= '0;
			any_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && !hit) begin
						hold_x_q <= pix.pix_x;
						hold_y_q <= pix.pix_y;
						hold_w_q <= in_w;
						hold_last_q <= pix.frame_end;
						edge_q <= '0;
						any_q <= 1'b0;
						state_q <= F_EDGE;
					end
				end
				F_EDGE: begin
					if (skip) begin
						edge_q <= edge_q + EdgeW'(1);
						if (edge_q == EdgeW'(NumEdges - 1)) begin
							state_q <= F_DONE;
						end
					end else begin
						x0_q <= xs_q[edge_q];
						ma_q <= magnitude(dx);
						mb_q <= magnitude(dy);
						dmag_q <= magnitude(den);
						neg_q <= dy[DiffW-1] ^ dx[DiffW-1] ^ den[DiffW-1];
						p_q <= '0;
						step_q <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					p_q <= {p_q[ProdW-2:0], 1'b0} + (mb_q[MagW-1] ? ProdW'(ma_q) : '0);
					mb_q <= {mb_q[MagW-2:0], 1'b0};
					step_q <= step_q + StepW'(1);
					if (step_q == StepW'(MagW - 1)) begin
						step_q <= '0;
						rem_q <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= qbit ? MagW'(rtrial - {1'b0, dmag_q}) : rtrial[MagW-1:0];
					p_q <= {p_q[ProdW-2:0], qbit};
					step_q <= step_q + StepW'(1);
					if (step_q == StepW'(ProdW - 1)) begin
						state_q <= F_ACC;
					end
				end
				F_ACC: begin
					if (!any_q || end_pos < lo_q) begin
						lo_q <= end_pos;
					end
					if (!any_q || end_pos > hi_q) begin
						hi_q <= end_pos;
					end
					any_q <= 1'b1;
					edge_q <= edge_q + EdgeW'(1);
					state_q <= (edge_q == EdgeW'(NumEdges - 1)) ? F_DONE : F_EDGE;
				end
				F_DONE: begin
					span_valid_q <= 1'b1;
					span_row_q <= hold_y_q;
					span_present_q <= any_q;
					span_left_q <= any_q ? lo_q : '0;
					span_right_q <= any_q ? hi_q : '0;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_room) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
			if (cfg.valid) begin
				span_valid_q <= 1'b0;
			end
		end
	end

	// A held pixel is only released against the span of its own row.
	a_push_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_PUSH |-> span_valid_q && span_row_q == hold_y_q)
		else $error("held pixel released against a foreign row span");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		span_present_q |-> span_left_q <= span_right_q)
		else $error("span ends out of order");

	a_miss_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !hit |=> state_q == F_EDGE)
		else $error("row miss did not start the span engine");

endmodule

/* src/qrca_fifo.sv */
// ----------------------------------------------------------------------------
// qrca_fifo
// Short queue of classified pixel words between the front and the back.
// ----------------------------------------------------------------------------
module qrca_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  qrca_pkg::cls_t push_data,
	output logic           push_room,
	output logic           pop_valid,
	output qrca_pkg::cls_t pop_data,
	input  logic           pop_ready
);
	import qrca_pkg::*;

	cls_t                mem_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_ptr_q;
	logic [FifoPtrW-1:0] rd_ptr_q;
	logic [FifoCntW-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_room = cnt_q != FifoCntW'(FifoDepth);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_room;
	assign do_pop = pop_valid && pop_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
			end
			cnt_q <= cnt_q + FifoCntW'(do_push) - FifoCntW'(do_pop);
		end
	end

endmodule

/* src/qrca_back.sv */
// ----------------------------------------------------------------------------
// qrca_back
// Accumulates covered pixels and, at the end of a frame, divides the sums by
// the pixel count with three bit-serial dividers into an output register.
// ----------------------------------------------------------------------------
module qrca_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  qrca_pkg::cls_t pop_data,
	output logic           pop_ready,
	qrca_res_if.source     res
);
	import qrca_pkg::*;

	typedef enum logic [1:0] {B_ACC, B_DIV, B_LOAD} bstate_t;

	localparam int StepW = 5;

	bstate_t           state_q;
	logic [SumW-1:0]   sum_q [NumChan];
	logic [CountW-1:0] total_q;
	logic [SumW-1:0]   dq_q [NumChan];
	logic [CountW-1:0] rq_q [NumChan];
	logic [CountW-1:0] den_q;
	logic [StepW-1:0]  step_q;
	logic              out_valid_q;
	logic [ChanW-1:0]  out_avg_q [NumChan];
	logic [CountW-1:0] out_count_q;

	logic              pop_fire;
	logic [SumW-1:0]   sum_n [NumChan];
	logic [CountW-1:0] total_n;
	logic [CountW:0]   rtrial [NumChan];
	logic              qbit [NumChan];

	assign pop_ready = state_q == B_ACC;
	assign pop_fire = pop_valid && pop_ready;

	// Saturating accumulation of the popped word.
	always_comb begin
		logic [SumW:0]   s;
		logic [CountW:0] t;
		for (int c = 0; c < NumChan; c++) begin
			s = {1'b0, sum_q[c]} + (SumW+1)'(pop_data.weight[c]);
			sum_n[c] = s[SumW] ? '1 : s[SumW-1:0];
		end
		t = {1'b0, total_q} + (CountW+1)'(1);
		total_n = t[CountW] ? '1 : t[CountW-1:0];
		if (!pop_data.covered) begin
			for (int c = 0; c < NumChan; c++) begin
				sum_n[c] = sum_q[c];
			end
			total_n = total_q;
		end
	end

	// One restoring divider step per channel.
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			rtrial[c] = {rq_q[c], dq_q[c][SumW-1]};
			qbit[c] = rtrial[c] >= {1'b0, den_q};
		end
	end

	// Frame sequencing and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_ACC;
			for (int c = 0; c < NumChan; c++) begin
				sum_q[c] <= '0;
			end
			total_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_ACC: begin
					if (pop_fire) begin
						if (pop_data.last) begin
							for (int c = 0; c < NumChan; c++) begin
								dq_q[c] <= sum_n[c];
								rq_q[c] <= '0;
								sum_q[c] <= '0;
							end
							den_q <= total_n;
							total_q <= '0;
							step_q <= '0;
							state_q <= B_DIV;
						end else begin
							for (int c = 0; c < NumChan; c++) begin
								sum_q[c] <= sum_n[c];
							end
							total_q <= total_n;
						end
					end
				end
				B_DIV: begin
					for (int c = 0; c < NumChan; c++) begin
						rq_q[c] <= qbit[c] ? CountW'(rtrial[c] - {1'b0, den_q})
							: rtrial[c][CountW-1:0];
						dq_q[c] <= {dq_q[c][SumW-2:0], qbit[c]};
					end
					step_q <= step_q + StepW'(1);
					if (step_q == StepW'(SumW - 1)) begin
						state_q <= B_LOAD;
					end
				end
				B_LOAD: begin
					if (!out_valid_q || res.ready) begin
						for (int c = 0; c < NumChan; c++) begin
							if (den_q == '0) begin
								out_avg_q[c] <= '0;
							end else if (dq_q[c][SumW-1:ChanW] != '0) begin
								out_avg_q[c] <= '1;
							end else begin
								out_avg_q[c] <= dq_q[c][ChanW-1:0];
							end
						end
						out_count_q <= den_q;
						out_valid_q <= 1'b1;
						state_q <= B_ACC;
					end
				end
				default: state_q <= B_ACC;
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.avg_red = out_avg_q[0];
	assign res.avg_green = out_avg_q[1];
	assign res.avg_blue = out_avg_q[2];
	assign res.covered_count = out_count_q;

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_count_q == '0 |->
		out_avg_q[0] == '0 && out_avg_q[1] == '0 && out_avg_q[2] == '0)
		else $error("empty frame produced a nonzero average");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV && step_q == StepW'(SumW - 1) |=> state_q == B_LOAD)
		else $error("divider did not finish after its last step");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop_fire && pop_data.last) |=> total_q >= $past(total_q))
		else $error("pixel count dropped inside a frame");

endmodule

/* src/quad_region_color_average.sv */
// ----------------------------------------------------------------------------
// quad_region_color_average
// Averages the alpha-weighted color of the pixels of a frame that fall inside
// a configured quadrilateral and reports it with the covered pixel count.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the row stays the same and the queue
// has room; a pixel on a new row holds intake while the shared span unit works
// on each crossing edge (set-up, 28 multiply steps, 56 divide steps and one
// update). A frame result runs a 32-step per-channel divider once its last
// pixel leaves the queue, then waits for a free output register. Reset clears
// the span cache, sums and count, and loads corners 0 and unit scales.
module quad_region_color_average (
	input  logic       clk,
	input  logic       arst_n,
	qrca_pix_if.sink   pix,
	qrca_cfg_if.sink   cfg,
	qrca_res_if.source res
);
	import qrca_pkg::*;

	logic push_valid;
	cls_t push_data;
	logic push_room;
	logic pop_valid;
	cls_t pop_data;
	logic pop_ready;

	// Span engine and pixel classification.
	qrca_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_room  (push_room)
	);

	// Decoupling queue.
	qrca_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_room  (push_room),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// Accumulation and averaging.
	qrca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.res       (res)
	);

endmodule
